FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SPOB_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define SPOB_NEVER(lbl, clk_s, rst_s, cond, msg) \
  `SPOB_ASSERT(lbl, clk_s, rst_s, !(cond), msg)

`endif

FILE: rtl/spob_pkg.sv
// ----------------------------------------------------------------------------
// spob_pkg
// types, codes and constants of the servo pwm output batcher
// ----------------------------------------------------------------------------
package spob_pkg;

  // actions
  localparam logic [2:0] ACT_WRITE   = 3'd0;
  localparam logic [2:0] ACT_CORK    = 3'd1;
  localparam logic [2:0] ACT_PUSH    = 3'd2;
  localparam logic [2:0] ACT_ENABLE  = 3'd3;
  localparam logic [2:0] ACT_DISABLE = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_DISABLE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // channel modes
  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_ONESHOT    = 2'd1;
  localparam logic [1:0] MODE_ONESHOT125 = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE0 = 3'd0;
  localparam logic [2:0] REG_MODE3 = 3'd3;
  localparam logic [2:0] REG_RATE0 = 3'd4;
  localparam logic [2:0] REG_RATE2 = 3'd6;

  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned NUM_TIMER  = 3;

  localparam logic [19:0] TICK_HZ      = 20'd1000000;
  localparam logic [15:0] RATE_MIN     = 16'd16;
  localparam logic [15:0] RATE_MAX     = 16'd50000;
  localparam logic [15:0] RESET_PERIOD = 16'd2500;
  localparam logic [15:0] BAD_READ     = 16'd900;
  localparam logic [15:0] MINP_ONESHOT    = 16'd100;
  localparam logic [15:0] MINP_ONESHOT125 = 16'd300;
  localparam logic [4:0]  DIV_STEPS    = 5'd20;

  // x*42/1000 as x*42*ceil(2^32/1000) >> 32, exact for 16-bit x
  localparam logic [27:0] ONESHOT_MUL = 28'd180388656;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  channel;
    logic [15:0] pulse_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  timer_index;
    logic        timer_channel;
    logic [15:0] compare_ticks;
    logic [15:0] period_ticks;
    logic [15:0] read_value;
    logic        last;
  } out_item_t;

  // classified item as queued between front and back
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  chan;
    logic        bad;
    logic [15:0] pulse;
  } cmd_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][1:0]   mode;
    logic [NUM_TIMER-1:0][15:0] period;
  } tcfg_t;

  typedef struct packed {
    logic sweeping;
    logic corked;
  } back_stat_t;

  function automatic logic [1:0] chan_timer(input logic [1:0] c);
    case (c)
      2'd0:    chan_timer = 2'd0;
      2'd1:    chan_timer = 2'd0;
      2'd2:    chan_timer = 2'd1;
      default: chan_timer = 2'd2;
    endcase
  endfunction

  function automatic logic chan_out(input logic [1:0] c);
    chan_out = (c == 2'd1);
  endfunction

  function automatic logic [15:0] mode_min(input logic [1:0] m);
    case (m)
      MODE_ONESHOT:    mode_min = MINP_ONESHOT;
      MODE_ONESHOT125: mode_min = MINP_ONESHOT125;
      default:         mode_min = 16'd0;
    endcase
  endfunction

endpackage

FILE: rtl/servo_pwm_output_batcher_core.sv
// ----------------------------------------------------------------------------
// servo_pwm_output_batcher_core
// four servo channels batched into compare commands for three pwm timers
// ----------------------------------------------------------------------------
//  channel  ports                                  direction
//  in       in_valid, in_ready, in_data            action items in
//  out      out_valid, out_ready, out_data         timer commands out
//  cfg      cfg_valid, cfg_ready, cfg_index/data   mode and rate registers
//
//  a write, enable, disable or read item gives at most one command; a push
//  gives one per changed channel (up to four), lowest channel first
//  a rate write runs a serial period divider; in_ready and cfg_ready are
//  low meanwhile
//  a two-entry queue lets the front keep taking items while the back waits
//  on out_ready
//  synchronous active-low reset; periods come out of reset at 2500 ticks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_pwm_output_batcher_core import spob_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tcfg_t      tcfg;
  logic       tcfg_busy;
  logic       q_valid, q_pop;
  cmd_t       q_cmd;
  back_stat_t stat;

  spob_tcfg u_tcfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tcfg      (tcfg),
    .busy      (tcfg_busy)
  );

  spob_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold     (tcfg_busy),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  spob_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tcfg      (tcfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat)
  );

  `SPOB_NEVER(a_no_accept_while_div, clk, rst_n, in_ready && tcfg_busy, "item taken during period divide")
  `SPOB_ASSERT(a_sweep_corked, clk, rst_n, stat.sweeping |-> stat.corked, "push sweep while uncorked")
  `SPOB_ASSERT(a_notlast_sweep, clk, rst_n, (out_valid && !out_data.last) |-> stat.sweeping, "item missing its last result")

endmodule

FILE: rtl/spob_front.sv
// ----------------------------------------------------------------------------
// spob_front
// accepts items, drops those with no effect, queues the rest for the back
// ----------------------------------------------------------------------------
module spob_front import spob_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     hold,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  cmd_t       q_mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       accept, keep, push;
  logic       bad;
  cmd_t       cmd;

  always_comb begin
    bad       = in_data.channel[2];
    cmd.op    = in_data.action;
    cmd.chan  = in_data.channel[1:0];
    cmd.bad   = bad;
    cmd.pulse = in_data.pulse_us;
    case (in_data.action)
      ACT_CORK, ACT_PUSH, ACT_READ:         keep = 1'b1;
      ACT_WRITE, ACT_ENABLE, ACT_DISABLE:   keep = !bad;
      default:                              keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2) && !hold;
  assign accept   = in_valid && in_ready;
  assign push     = accept && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

FILE: rtl/spob_tcfg.sv
// ----------------------------------------------------------------------------
// spob_tcfg
// channel modes and timer periods, with a bit-serial period divider
// ----------------------------------------------------------------------------
module spob_tcfg import spob_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output tcfg_t       tcfg,
  output logic        busy
);

  logic [NUM_CHAN-1:0][1:0]   mode_r;
  logic [NUM_TIMER-1:0][15:0] period_r;
  logic [4:0]  cnt_r;
  logic [1:0]  tsel_r;
  logic [15:0] den_r, rem_r, quot_r;
  logic [19:0] num_r;
  logic [16:0] trial, diff;
  logic        ge, wr;
  logic [15:0] rate_sat;
  logic [2:0]  tidx;

  assign busy      = (cnt_r != 5'd0);
  assign cfg_ready = !busy;
  assign wr        = cfg_valid && cfg_ready;
  assign tcfg.mode   = mode_r;
  assign tcfg.period = period_r;

  always_comb begin
    if (cfg_data < RATE_MIN) begin
      rate_sat = RATE_MIN;
    end else if (cfg_data > RATE_MAX) begin
      rate_sat = RATE_MAX;
    end else begin
      rate_sat = cfg_data;
    end
    tidx  = cfg_index - REG_RATE0;
    trial = {rem_r, num_r[19]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      period_r <= {NUM_TIMER{RESET_PERIOD}};
      cnt_r    <= 5'd0;
    end else begin
      if (wr) begin
        if (cfg_index inside {[REG_MODE0:REG_MODE3]}) begin
          mode_r[cfg_index[1:0]] <= cfg_data[1:0];
        end else if (cfg_index inside {[REG_RATE0:REG_RATE2]}) begin
          cnt_r <= DIV_STEPS;
        end
      end else if (busy) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          period_r[tsel_r] <= {quot_r[14:0], ge};
        end
      end
    end
  end

  // restoring division of the tick rate, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (wr) begin
      tsel_r <= tidx[1:0];
      den_r  <= rate_sat;
      num_r  <= TICK_HZ;
      rem_r  <= 16'd0;
      quot_r <= 16'd0;
    end else if (busy) begin
      num_r  <= {num_r[18:0], 1'b0};
      rem_r  <= ge ? diff[15:0] : trial[15:0];
      quot_r <= {quot_r[14:0], ge};
    end
  end

endmodule

FILE: rtl/spob_back.sv
// ----------------------------------------------------------------------------
// spob_back
// carries out queued commands, holds servo state and the result register
// ----------------------------------------------------------------------------
module spob_back import spob_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tcfg_t      tcfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  output back_stat_t stat
);

  logic [NUM_CHAN-1:0][15:0] pending_r, pending_nxt;
  logic [NUM_CHAN-1:0][15:0] sent_r, sent_nxt;
  logic [NUM_CHAN-1:0]       mask_r, mask_nxt, diff_mask, mask_rest;
  logic      corked_r, corked_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      slot_free, emit, sweeping;
  logic [1:0]  sw_ch, sel_ch, sel_timer, sel_mode;
  logic [15:0] sel_pulse, scaled, minp, period;
  logic [43:0] prod;
  out_item_t res;

  assign slot_free = !out_valid_r || out_ready;
  assign sweeping  = |mask_r;

  always_comb begin
    sw_ch = 2'd0;
    for (int i = NUM_CHAN - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sw_ch = 2'(i);
      end
    end
    for (int i = 0; i < NUM_CHAN; i++) begin
      diff_mask[i] = (pending_r[i] != sent_r[i]);
    end
    mask_rest        = mask_r;
    mask_rest[sw_ch] = 1'b0;
  end

  // channel and pulse that a compare or disable command would address
  always_comb begin
    sel_ch    = sweeping ? sw_ch : q_cmd.chan;
    if (sweeping) begin
      sel_pulse = pending_r[sw_ch];
    end else if (q_cmd.op == ACT_WRITE) begin
      sel_pulse = q_cmd.pulse;
    end else begin
      sel_pulse = pending_r[q_cmd.chan];
    end
    sel_mode  = tcfg.mode[sel_ch];
    sel_timer = chan_timer(sel_ch);
    prod      = 44'(sel_pulse) * 44'(ONESHOT_MUL);
    case (sel_mode)
      MODE_ONESHOT:    scaled = {4'd0, prod[43:32]};
      MODE_ONESHOT125: scaled = {3'd0, sel_pulse[15:3]};
      default:         scaled = sel_pulse;
    endcase
    case (sel_timer)
      2'd0: begin
        minp = (mode_min(tcfg.mode[0]) > mode_min(tcfg.mode[1])) ?
               mode_min(tcfg.mode[0]) : mode_min(tcfg.mode[1]);
      end
      2'd1:    minp = mode_min(tcfg.mode[2]);
      default: minp = mode_min(tcfg.mode[3]);
    endcase
    period = (tcfg.period[sel_timer] > minp) ? tcfg.period[sel_timer] : minp;
  end

  always_comb begin
    pending_nxt = pending_r;
    sent_nxt    = sent_r;
    mask_nxt    = mask_r;
    corked_nxt  = corked_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    res.kind          = KIND_SET;
    res.timer_index   = sel_timer;
    res.timer_channel = chan_out(sel_ch);
    res.compare_ticks = scaled;
    res.period_ticks  = period;
    res.read_value    = 16'd0;
    res.last          = 1'b1;
    if (sweeping) begin
      if (slot_free) begin
        emit            = 1'b1;
        res.last        = (mask_rest == '0);
        sent_nxt[sw_ch] = pending_r[sw_ch];
        mask_nxt        = mask_rest;
        if (mask_rest == '0) begin
          corked_nxt = 1'b0;
        end
      end
    end else if (q_valid) begin
      case (q_cmd.op)
        ACT_WRITE: begin
          if (corked_r) begin
            pending_nxt[q_cmd.chan] = q_cmd.pulse;
            q_pop                   = 1'b1;
          end else if (slot_free) begin
            pending_nxt[q_cmd.chan] = q_cmd.pulse;
            sent_nxt[q_cmd.chan]    = q_cmd.pulse;
            emit                    = 1'b1;
            q_pop                   = 1'b1;
          end
        end
        ACT_CORK: begin
          corked_nxt = 1'b1;
          q_pop      = 1'b1;
        end
        ACT_PUSH: begin
          q_pop = 1'b1;
          if (corked_r) begin
            if (diff_mask == '0) begin
              corked_nxt = 1'b0;
            end else begin
              mask_nxt = diff_mask;
            end
          end
        end
        ACT_ENABLE: begin
          if (slot_free) begin
            emit  = 1'b1;
            q_pop = 1'b1;
          end
        end
        ACT_DISABLE: begin
          if (slot_free) begin
            emit              = 1'b1;
            q_pop             = 1'b1;
            res.kind          = KIND_DISABLE;
            res.compare_ticks = 16'd0;
          end
        end
        ACT_READ: begin
          if (slot_free) begin
            emit              = 1'b1;
            q_pop             = 1'b1;
            res.kind          = KIND_READ;
            res.timer_index   = 2'd0;
            res.timer_channel = 1'b0;
            res.compare_ticks = 16'd0;
            res.period_ticks  = 16'd0;
            res.read_value    = q_cmd.bad ? BAD_READ : pending_r[q_cmd.chan];
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      sent_r      <= '0;
      mask_r      <= '0;
      corked_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      sent_r      <= sent_nxt;
      mask_r      <= mask_nxt;
      corked_r    <= corked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.sweeping = sweeping;
  assign stat.corked   = corked_r;

endmodule

FILE: tb/servo_pwm_output_batcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pwm_output_batcher_core_tb
// self-checking bench for the servo pwm output batcher: action items go in
// through a valid/ready port with random gaps, timer commands are taken with
// random stalls, and every command is compared field by field against a
// shadow of the channel state, cork flag, modes and timer rates
// ----------------------------------------------------------------------------
module servo_pwm_output_batcher_core_tb;
  import spob_pkg::*;

  localparam logic [2:0]      ACT_SPARE6    = 3'd6;
  localparam logic [2:0]      ACT_SPARE7    = 3'd7;
  localparam logic [2:0]      REG_SPARE     = 3'd7;
  localparam logic [1:0]      MODE_SPARE    = 2'd3;
  localparam logic [15:0]     RESET_RATE    = 16'd400;
  localparam int unsigned     SETTLE_CYCLES = 24;
  // channel to timer map, and the channels that sit on output b
  localparam logic [3:0][1:0] TIMER_MAP     = {2'd2, 2'd1, 2'd0, 2'd0};
  localparam logic [3:0]      ON_OUT_B      = 4'b0010;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // shadow of the block
  logic [1:0]  mode_r [NUM_CHAN];
  logic [15:0] rate_r [NUM_TIMER];
  logic [15:0] pending_us [NUM_CHAN];
  logic [15:0] sent_us [NUM_CHAN];
  logic        corked;
  out_item_t   timer_cmds [$];
  int          errors = 0;
  bit          steady;

  servo_pwm_output_batcher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] scaled_compare(input logic [1:0] c, input logic [15:0] us);
    int unsigned prod;
    case (mode_r[c])
      MODE_ONESHOT125: return us >> 3;
      MODE_ONESHOT: begin
        prod = 32'(us) * 32'd42;
        prod = prod / 32'd1000;
        return 16'(prod);
      end
      default: return us;
    endcase
  endfunction

  function automatic out_item_t make_cmd(input logic [1:0] kind, input logic [1:0] c,
                                         input logic [15:0] cmp, input logic with_timer,
                                         input logic [15:0] readv);
    out_item_t   r;
    int unsigned rate;
    int unsigned ticks;
    int unsigned floor_ticks;
    logic [1:0]  t;
    r = '0;
    r.kind = kind;
    r.compare_ticks = cmp;
    r.read_value = readv;
    if (with_timer) begin
      t = TIMER_MAP[c];
      rate = rate_r[t];
      if (rate < RATE_MIN) rate = RATE_MIN;
      if (rate > RATE_MAX) rate = RATE_MAX;
      ticks = TICK_HZ / rate;
      // the strictest mode among the channels sharing the timer sets the floor
      floor_ticks = 0;
      for (int i = 0; i < NUM_CHAN; i++) begin
        if (TIMER_MAP[i] == t) begin
          if (mode_r[i] == MODE_ONESHOT && floor_ticks < MINP_ONESHOT)
            floor_ticks = MINP_ONESHOT;
          if (mode_r[i] == MODE_ONESHOT125 && floor_ticks < MINP_ONESHOT125)
            floor_ticks = MINP_ONESHOT125;
        end
      end
      r.timer_index = t;
      r.timer_channel = ON_OUT_B[c];
      r.period_ticks = 16'((ticks > floor_ticks) ? ticks : floor_ticks);
    end
    return r;
  endfunction

  // commands that one action item gives rise to
  task automatic batch_action(input in_item_t it);
    out_item_t  res [4];
    int         n;
    logic [1:0] c;
    logic       ok;
    n = 0;
    c = it.channel[1:0];
    ok = (it.channel < NUM_CHAN);
    case (it.action)
      ACT_WRITE: begin
        if (ok) begin
          pending_us[c] = it.pulse_us;
          if (!corked) begin
            sent_us[c] = it.pulse_us;
            res[n] = make_cmd(KIND_SET, c, scaled_compare(c, it.pulse_us), 1'b1, '0);
            n++;
          end
        end
      end
      ACT_CORK: corked = 1'b1;
      ACT_PUSH: begin
        if (corked) begin
          for (int i = 0; i < NUM_CHAN; i++) begin
            if (pending_us[i] != sent_us[i]) begin
              sent_us[i] = pending_us[i];
              res[n] = make_cmd(KIND_SET, 2'(i), scaled_compare(2'(i), pending_us[i]),
                                1'b1, '0);
              n++;
            end
          end
          corked = 1'b0;
        end
      end
      ACT_ENABLE: begin
        if (ok) begin
          res[n] = make_cmd(KIND_SET, c, scaled_compare(c, pending_us[c]), 1'b1, '0);
          n++;
        end
      end
      ACT_DISABLE: begin
        if (ok) begin
          res[n] = make_cmd(KIND_DISABLE, c, '0, 1'b1, '0);
          n++;
        end
      end
      ACT_READ: begin
        res[n] = make_cmd(KIND_READ, 2'd0, '0, 1'b0, ok ? pending_us[c] : BAD_READ);
        n++;
      end
      default: ;
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) timer_cmds.push_back(res[i]);
  endtask

  task automatic field_check(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // prediction, register shadow and result checking, all sampled at the edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        mode_r[i] = MODE_NORMAL;
        pending_us[i] = '0;
        sent_us[i] = '0;
      end
      for (int i = 0; i < NUM_TIMER; i++) rate_r[i] = RESET_RATE;
      corked = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= REG_MODE3)
          mode_r[cfg_index[1:0]] = cfg_data[1:0];
        else if (cfg_index <= REG_RATE2)
          rate_r[cfg_index - REG_RATE0] = cfg_data;
      end
      if (in_valid && in_ready) batch_action(in_data);
      if (out_valid && out_ready) begin
        if (timer_cmds.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_data);
          errors++;
        end else begin
          want = timer_cmds.pop_front();
          field_check("kind", want.kind, out_data.kind);
          field_check("timer_index", want.timer_index, out_data.timer_index);
          field_check("timer_channel", want.timer_channel, out_data.timer_channel);
          field_check("compare_ticks", want.compare_ticks, out_data.compare_ticks);
          field_check("period_ticks", want.period_ticks, out_data.period_ticks);
          field_check("read_value", want.read_value, out_data.read_value);
          field_check("last", want.last, out_data.last);
        end
      end
    end
  end

  // result side: a fresh stall before every result
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [2:0] ch, input logic [15:0] us);
    in_item_t it;
    int       gap;
    it.action = act;
    it.channel = ch;
    it.pulse_us = us;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all outstanding commands, then let silent items finish too
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (timer_cmds.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [1:0] m0, input logic [1:0] m1,
                               input logic [1:0] m2, input logic [1:0] m3,
                               input logic [15:0] r0, input logic [15:0] r1,
                               input logic [15:0] r2);
    logic [3:0][1:0]  modes;
    logic [2:0][15:0] rates;
    modes = {m3, m2, m1, m0};
    rates = {r2, r1, r0};
    drain();
    // upper bits of a mode write carry junk
    for (int i = 0; i < NUM_CHAN; i++)
      write_reg(REG_MODE0 + 3'(i), {14'($urandom), modes[i]});
    for (int i = 0; i < NUM_TIMER; i++)
      write_reg(REG_RATE0 + 3'(i), rates[i]);
  endtask

  function automatic logic [15:0] draw_pulse();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1, 2:    return 16'($urandom);
      3:       return 16'(500 * $urandom_range(2, 4));
      default: return 16'($urandom_range(800, 2200));
    endcase
  endfunction

  function automatic logic [2:0] draw_channel();
    if ($urandom_range(0, 9) != 0) return 3'($urandom_range(0, 3));
    return 3'($urandom_range(4, 7));
  endfunction

  function automatic logic [2:0] draw_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return ACT_WRITE;
    if (r < 45) return ACT_CORK;
    if (r < 55) return ACT_PUSH;
    if (r < 65) return ACT_ENABLE;
    if (r < 73) return ACT_DISABLE;
    if (r < 96) return ACT_READ;
    return r[0] ? ACT_SPARE6 : ACT_SPARE7;
  endfunction

  function automatic logic [15:0] draw_rate();
    case ($urandom_range(0, 7))
      0:       return RATE_MIN;
      1:       return RATE_MAX;
      2:       return 16'($urandom_range(0, 15));
      3:       return 16'($urandom_range(50001, 65535));
      4, 5:    return 16'($urandom_range(2500, 12000));
      default: return 16'($urandom_range(50, 1000));
    endcase
  endfunction

  // each channel written twice, enabled and read once, plus a cork, a push and one disable
  task automatic sweep_channels();
    for (int c = 0; c < NUM_CHAN; c++) send_item(ACT_WRITE, 3'(c), draw_pulse());
    for (int c = 0; c < NUM_CHAN; c++) send_item(ACT_ENABLE, 3'(c), '0);
    send_item(ACT_CORK, '0, '0);
    for (int c = 0; c < NUM_CHAN; c++) send_item(ACT_WRITE, 3'(c), 16'($urandom));
    send_item(ACT_PUSH, '0, '0);
    for (int c = 0; c < NUM_CHAN; c++) send_item(ACT_READ, 3'(c), '0);
    send_item(ACT_DISABLE, 3'($urandom_range(0, 3)), '0);
  endtask

  // mostly cork / writes / push batches, the rest single actions and noise
  task automatic run_traffic(input int n_items);
    int         sent;
    int         burst;
    logic [2:0] act;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 15) == 0) steady = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 2) != 0) begin
        send_item(ACT_CORK, draw_channel(), 16'($urandom));
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          if ($urandom_range(0, 4) == 0)
            send_item(draw_action(), draw_channel(), draw_pulse());
          else
            send_item(ACT_WRITE, draw_channel(), draw_pulse());
        end
        // now and then the batch is left corked
        if ($urandom_range(0, 7) != 0) send_item(ACT_PUSH, draw_channel(), 16'($urandom));
        sent += burst + 2;
      end else begin
        act = draw_action();
        send_item(act, draw_channel(), draw_pulse());
        if (act != ACT_SPARE6 && act != ACT_SPARE7) sent++;
      end
    end
  endtask

  task automatic test_directed_actions();
    send_item(ACT_READ, 3'd0, '0);
    send_item(ACT_WRITE, 3'd0, 16'hFFFF);
    send_item(ACT_WRITE, 3'd1, 16'h0000);
    send_item(ACT_WRITE, 3'd2, 16'd1500);
    send_item(ACT_WRITE, 3'd3, 16'd1000);
    send_item(ACT_READ, 3'd3, '0);
    send_item(ACT_ENABLE, 3'd2, '0);
    send_item(ACT_DISABLE, 3'd1, '0);
    // out of range channels: only the read answers
    send_item(ACT_WRITE, 3'd4, 16'd1234);
    send_item(ACT_ENABLE, 3'd7, '0);
    send_item(ACT_DISABLE, 3'd5, '0);
    send_item(ACT_READ, 3'd6, '0);
    send_item(ACT_SPARE6, 3'd0, 16'hFFFF);
    send_item(ACT_SPARE7, 3'd3, 16'h5A5A);
    send_item(ACT_PUSH, 3'd0, '0);
    send_item(ACT_CORK, 3'd0, '0);
    send_item(ACT_PUSH, 3'd0, '0);
    send_item(ACT_CORK, 3'd0, '0);
    send_item(ACT_WRITE, 3'd1, 16'd2000);
    send_item(ACT_WRITE, 3'd3, 16'd1000);
    // enable sends the held value but leaves it unsent for the push
    send_item(ACT_ENABLE, 3'd1, '0);
    send_item(ACT_WRITE, 3'd2, 16'd999);
    send_item(ACT_CORK, 3'd0, '0);
    send_item(ACT_PUSH, 3'd0, '0);
    send_item(ACT_READ, 3'd1, '0);
  endtask

  task automatic test_register_extremes();
    apply_setting(MODE_ONESHOT, MODE_ONESHOT, MODE_ONESHOT, MODE_ONESHOT,
                  RATE_MAX, RATE_MAX, RATE_MAX);
    sweep_channels();
    apply_setting(MODE_ONESHOT125, MODE_NORMAL, MODE_ONESHOT125, MODE_ONESHOT125,
                  RATE_MIN, RATE_MIN, RATE_MIN);
    sweep_channels();
    // rates outside the legal range, and the unused mode code
    apply_setting(MODE_SPARE, MODE_ONESHOT125, MODE_ONESHOT, MODE_NORMAL,
                  16'd0, 16'hFFFF, 16'd3333);
    sweep_channels();
    apply_setting(MODE_NORMAL, MODE_NORMAL, MODE_NORMAL, MODE_NORMAL,
                  RESET_RATE, 16'd5000, 16'd50001);
    write_reg(REG_SPARE, 16'hFFFF);
    sweep_channels();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      apply_setting(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    draw_rate(), draw_rate(), draw_rate());
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom));
      run_traffic(44);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_actions();
    test_register_extremes();
    test_random_traffic();
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/spob_pkg.sv
rtl/spob_front.sv
rtl/spob_tcfg.sv
rtl/spob_back.sv
rtl/servo_pwm_output_batcher_core.sv
tb/servo_pwm_output_batcher_core_tb.sv
